[design/jtlmf_pkg.sv]
package jtlmf_pkg;

    localparam int KEY_BYTES     = 16;
    localparam int KEY_IDX_BITS  = 4;
    localparam int KEY_LEN_BITS  = 5;
    localparam int KEY_WORD_BITS = 64;
    localparam int OFFSET_BITS   = 16;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [KEY_LEN_BITS-1:0] KEY_LEN_MAX  = KEY_LEN_BITS'(KEY_BYTES);
    localparam logic [KEY_LEN_BITS-1:0] NAME_IDX_SAT = '1;

    localparam logic signed [7:0] DEPTH_MAX = 8'sd127;
    localparam logic signed [7:0] DEPTH_MIN = -8'sd128;
    localparam logic signed [7:0] DEPTH_TOP = 8'sd1;

    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_KEY_LEN  = 2'd0,
        CFG_KEY_LOW  = 2'd1,
        CFG_KEY_HIGH = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_TOO_LONG  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        PH_OUTSIDE     = 4'd0,
        PH_NAME        = 4'd1,
        PH_NAME_ESC    = 4'd2,
        PH_SEEK_COLON  = 4'd3,
        PH_SKIP_WS     = 4'd4,
        PH_VAL_BARE    = 4'd5,
        PH_VAL_STR     = 4'd6,
        PH_VAL_STR_ESC = 4'd7,
        PH_DONE        = 4'd8
    } t_phase;

    typedef struct packed {
        logic [KEY_LEN_BITS-1:0]          len;
        logic [KEY_BYTES-1:0][7:0]        bytes;
    } t_key;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_document;
    } t_item;

    typedef struct packed {
        t_status                status;
        logic [OFFSET_BITS-1:0] value_begin;
        logic [OFFSET_BITS:0]   value_end;
    } t_result;

endpackage

[design/jtlmf_intf.sv]
interface jtlmf_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_document;

    modport source (output valid, output data_byte, output end_of_document, input ready);
    modport sink   (input valid, input data_byte, input end_of_document, output ready);
endinterface

interface jtlmf_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           status;
    logic [jtlmf_pkg::OFFSET_BITS-1:0]    value_begin;
    logic [jtlmf_pkg::OFFSET_BITS:0]      value_end;

    modport source (output valid, output status, output value_begin, output value_end,
                    input ready);
    modport sink   (input valid, input status, input value_begin, input value_end,
                    output ready);
endinterface

interface jtlmf_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [jtlmf_pkg::CFG_IDX_BITS-1:0]   reg_index;
    logic [jtlmf_pkg::KEY_WORD_BITS-1:0]  write_data;

    modport source (output valid, output reg_index, output write_data, input ready);
    modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

[design/jtlmf_cfg_regs.sv]
module jtlmf_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [jtlmf_pkg::CFG_IDX_BITS-1:0]  i_wr_index,
    input  logic [jtlmf_pkg::KEY_WORD_BITS-1:0] i_wr_data,
    output jtlmf_pkg::t_key                     o_key
);

    logic [jtlmf_pkg::KEY_LEN_BITS-1:0]  r_key_len;
    logic [jtlmf_pkg::KEY_WORD_BITS-1:0] r_key_low;
    logic [jtlmf_pkg::KEY_WORD_BITS-1:0] r_key_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len  <= '0;
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_wr_en) begin
            case (i_wr_index)
                jtlmf_pkg::CFG_KEY_LEN:  r_key_len  <= i_wr_data[jtlmf_pkg::KEY_LEN_BITS-1:0];
                jtlmf_pkg::CFG_KEY_LOW:  r_key_low  <= i_wr_data;
                jtlmf_pkg::CFG_KEY_HIGH: r_key_high <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_key.len   = r_key_len;
    assign o_key.bytes = {r_key_high, r_key_low};

endmodule

[design/jtlmf_in_stage.sv]
module jtlmf_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  jtlmf_pkg::t_item i_item,
    output logic             o_ready,
    output logic             o_valid,
    output jtlmf_pkg::t_item o_item,
    input  logic             i_pop
);

    logic             r_valid;
    jtlmf_pkg::t_item r_item;

    // slot is free when empty or drained this cycle
    assign o_ready = !r_valid || i_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[design/jtlmf_scanner.sv]
module jtlmf_scanner (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  jtlmf_pkg::t_item   i_item,
    input  jtlmf_pkg::t_key    i_key,
    output logic               o_hit,
    output jtlmf_pkg::t_result o_result
);

    logic [jtlmf_pkg::OFFSET_BITS:0]    r_offset, n_offset;
    logic signed [7:0]                  r_depth, n_depth;
    jtlmf_pkg::t_phase                  r_phase, n_phase;
    logic [jtlmf_pkg::KEY_LEN_BITS-1:0] r_name_idx, n_name_idx;
    logic                               r_name_mis, n_name_mis;
    logic [jtlmf_pkg::OFFSET_BITS-1:0]  r_span, n_span;

    logic [7:0] b;
    logic       eod;
    logic       too_long;
    logic       byte_ws;
    logic       key_ok;
    logic       name_miss;
    logic [jtlmf_pkg::KEY_LEN_BITS-1:0] name_idx_inc;
    logic [jtlmf_pkg::OFFSET_BITS:0]    offset_inc;

    assign b        = i_item.data_byte;
    assign eod      = i_item.end_of_document;
    assign too_long = r_offset[jtlmf_pkg::OFFSET_BITS];
    assign byte_ws  = (b == jtlmf_pkg::CH_SPACE)
                   || (b >= jtlmf_pkg::CH_TAB && b <= jtlmf_pkg::CH_CR);
    assign key_ok   = (i_key.len <= jtlmf_pkg::KEY_LEN_MAX);
    assign name_miss = !key_ok || (r_name_idx >= i_key.len)
                    || (b != i_key.bytes[r_name_idx[jtlmf_pkg::KEY_IDX_BITS-1:0]]);
    assign name_idx_inc = (r_name_idx == jtlmf_pkg::NAME_IDX_SAT) ? r_name_idx
                                                                : r_name_idx + 1'b1;
    assign offset_inc = r_offset + 1'b1;

    always_comb begin
        n_offset   = r_offset;
        n_depth    = r_depth;
        n_phase    = r_phase;
        n_name_idx = r_name_idx;
        n_name_mis = r_name_mis;
        n_span     = r_span;
        o_hit      = 1'b0;
        o_result   = '{status: jtlmf_pkg::ST_FOUND, value_begin: '0, value_end: '0};

        if (r_phase != jtlmf_pkg::PH_DONE) begin
            if (too_long) begin
                o_hit           = 1'b1;
                o_result.status = jtlmf_pkg::ST_TOO_LONG;
                n_phase         = jtlmf_pkg::PH_DONE;
            end else begin
                case (r_phase)
                    jtlmf_pkg::PH_OUTSIDE: begin
                        if (b == jtlmf_pkg::CH_QUOTE) begin
                            n_phase    = jtlmf_pkg::PH_NAME;
                            n_name_idx = '0;
                            n_name_mis = (r_depth != jtlmf_pkg::DEPTH_TOP);
                        end else if (b == jtlmf_pkg::CH_LBRACE || b == jtlmf_pkg::CH_LBRACK) begin
                            if (r_depth < jtlmf_pkg::DEPTH_MAX) n_depth = r_depth + 8'sd1;
                        end else if (b == jtlmf_pkg::CH_RBRACE || b == jtlmf_pkg::CH_RBRACK) begin
                            if (r_depth > jtlmf_pkg::DEPTH_MIN) n_depth = r_depth - 8'sd1;
                        end
                    end
                    jtlmf_pkg::PH_NAME: begin
                        if (b == jtlmf_pkg::CH_QUOTE) begin
                            if (!r_name_mis && r_name_idx == i_key.len && key_ok)
                                n_phase = jtlmf_pkg::PH_SEEK_COLON;
                            else
                                n_phase = jtlmf_pkg::PH_OUTSIDE;
                        end else begin
                            n_name_mis = r_name_mis || name_miss;
                            n_name_idx = name_idx_inc;
                            if (b == jtlmf_pkg::CH_BSLASH) n_phase = jtlmf_pkg::PH_NAME_ESC;
                        end
                    end
                    jtlmf_pkg::PH_NAME_ESC: begin
                        n_name_mis = r_name_mis || name_miss;
                        n_name_idx = name_idx_inc;
                        n_phase    = jtlmf_pkg::PH_NAME;
                    end
                    jtlmf_pkg::PH_SEEK_COLON: begin
                        if (b == jtlmf_pkg::CH_COLON) n_phase = jtlmf_pkg::PH_SKIP_WS;
                    end
                    jtlmf_pkg::PH_SKIP_WS: begin
                        if (!byte_ws) begin
                            n_span = r_offset[jtlmf_pkg::OFFSET_BITS-1:0];
                            if (b == jtlmf_pkg::CH_QUOTE) begin
                                n_phase = jtlmf_pkg::PH_VAL_STR;
                            end else if (b == jtlmf_pkg::CH_COMMA
                                         || b == jtlmf_pkg::CH_RBRACE) begin
                                // empty bare value
                                o_hit                = 1'b1;
                                o_result.value_begin = r_offset[jtlmf_pkg::OFFSET_BITS-1:0];
                                o_result.value_end   = r_offset;
                                n_phase              = jtlmf_pkg::PH_DONE;
                            end else begin
                                n_phase = jtlmf_pkg::PH_VAL_BARE;
                            end
                        end
                    end
                    jtlmf_pkg::PH_VAL_BARE: begin
                        if (b == jtlmf_pkg::CH_COMMA || b == jtlmf_pkg::CH_RBRACE || byte_ws) begin
                            o_hit                = 1'b1;
                            o_result.value_begin = r_span;
                            o_result.value_end   = r_offset;
                            n_phase              = jtlmf_pkg::PH_DONE;
                        end
                    end
                    jtlmf_pkg::PH_VAL_STR: begin
                        if (b == jtlmf_pkg::CH_BSLASH) begin
                            n_phase = jtlmf_pkg::PH_VAL_STR_ESC;
                        end else if (b == jtlmf_pkg::CH_QUOTE) begin
                            o_hit                = 1'b1;
                            o_result.value_begin = r_span;
                            o_result.value_end   = offset_inc;
                            n_phase              = jtlmf_pkg::PH_DONE;
                        end
                    end
                    jtlmf_pkg::PH_VAL_STR_ESC: begin
                        n_phase = jtlmf_pkg::PH_VAL_STR;
                    end
                    default: ;
                endcase
            end
        end

        if (eod) begin
            if (!o_hit && n_phase != jtlmf_pkg::PH_DONE) begin
                o_hit = 1'b1;
                if (n_phase == jtlmf_pkg::PH_VAL_BARE) begin
                    // bare value runs to the last byte
                    o_result.value_begin = n_span;
                    o_result.value_end   = offset_inc;
                end else if (n_phase == jtlmf_pkg::PH_OUTSIDE) begin
                    o_result.status = jtlmf_pkg::ST_NOT_FOUND;
                end else begin
                    o_result.status = jtlmf_pkg::ST_MALFORMED;
                end
            end
            n_offset   = '0;
            n_depth    = '0;
            n_phase    = jtlmf_pkg::PH_OUTSIDE;
            n_name_idx = '0;
            n_name_mis = 1'b0;
            n_span     = '0;
        end else if (n_phase != jtlmf_pkg::PH_DONE && !too_long) begin
            n_offset = offset_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= '0;
            r_depth    <= '0;
            r_phase    <= jtlmf_pkg::PH_OUTSIDE;
            r_name_idx <= '0;
            r_name_mis <= 1'b0;
            r_span     <= '0;
        end else if (i_go) begin
            r_offset   <= n_offset;
            r_depth    <= n_depth;
            r_phase    <= n_phase;
            r_name_idx <= n_name_idx;
            r_name_mis <= n_name_mis;
            r_span     <= n_span;
        end
    end

endmodule

[design/jtlmf_out_stage.sv]
module jtlmf_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  jtlmf_pkg::t_result i_result,
    output logic               o_space,
    output logic               o_valid,
    input  logic               i_ready,
    output jtlmf_pkg::t_result o_result
);

    logic               r_valid;
    jtlmf_pkg::t_result r_result;

    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[design/json_top_level_member_finder.sv]
// a result is registered in the result register once its byte has left the input register
// throughput: one byte per cycle unless a waiting result stalls the scan; the scanner state
// update is one short pass per byte; an input register and a result register part the two
// channels, so a waiting result stalls the input only once the input register is also full
// reset: synchronous, active low; clears the key registers, the scan state and both
// valid flags; no clearing pass, the block is ready on the cycle after reset
module json_top_level_member_finder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    jtlmf_item_if.sink            i_item,
    jtlmf_result_if.source        o_result,
    jtlmf_cfg_if.sink             i_cfg
);

    jtlmf_pkg::t_key    w_key;
    jtlmf_pkg::t_item   w_in_item;
    jtlmf_pkg::t_item   w_stage_item;
    jtlmf_pkg::t_result w_scan_result;
    jtlmf_pkg::t_result w_out_result;
    logic               w_stage_valid;
    logic               w_out_space;
    logic               w_go;
    logic               w_hit;

    // configuration writes are always taken
    assign i_cfg.ready = 1'b1;

    jtlmf_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.reg_index),
        .i_wr_data  (i_cfg.write_data),
        .o_key      (w_key)
    );

    assign w_in_item.data_byte       = i_item.data_byte;
    assign w_in_item.end_of_document = i_item.end_of_document;

    // input register: holds one byte while the result register is blocked
    jtlmf_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .i_item  (w_in_item),
        .o_ready (i_item.ready),
        .o_valid (w_stage_valid),
        .o_item  (w_stage_item),
        .i_pop   (w_go)
    );

    // a byte is scanned only when its possible result has somewhere to go
    assign w_go = w_stage_valid && w_out_space;

    // scan state machine: phase, depth, offset and key compare for one byte
    jtlmf_scanner u_scanner (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_go),
        .i_item   (w_stage_item),
        .i_key    (w_key),
        .o_hit    (w_hit),
        .o_result (w_scan_result)
    );

    // result register: at most one transaction per document
    jtlmf_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_go && w_hit),
        .i_result (w_scan_result),
        .o_space  (w_out_space),
        .o_valid  (o_result.valid),
        .i_ready  (o_result.ready),
        .o_result (w_out_result)
    );

    assign o_result.status      = w_out_result.status;
    assign o_result.value_begin = w_out_result.value_begin;
    assign o_result.value_end   = w_out_result.value_end;

endmodule

[verif/json_top_level_member_finder_tb.sv]
module json_top_level_member_finder_tb;
    import jtlmf_pkg::*;

    // the run stops here even if a channel hangs
    localparam int CYCLE_LIMIT   = 2_000_000;
    // results pass an input register and a result register, leave some margin
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_REPORTED  = 10;

    logic clk;
    logic rst_n;

    jtlmf_item_if   item_if();
    jtlmf_result_if res_if();
    jtlmf_cfg_if    cfg_if();

    json_top_level_member_finder u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    // idle percentages for the byte sender and the result receiver
    int src_idle_pct = 0;
    int snk_idle_pct = 0;

    // spans and statuses still owed by the block, oldest first
    t_result    pending_reports[$];
    // bytes of the document being assembled
    logic [7:0] doc_bytes[$];

    int docs_sent       = 0;
    int bytes_sent      = 0;
    int results_checked = 0;
    int err_count       = 0;
    int reg_writes      = 0;
    int cycle_count     = 0;

    // mirrored key registers
    logic [KEY_LEN_BITS-1:0]  key_len_copy;
    logic [KEY_WORD_BITS-1:0] key_lo_copy;
    logic [KEY_WORD_BITS-1:0] key_hi_copy;

    // mirrored scanner state
    logic [OFFSET_BITS:0]     pr_pos;
    logic signed [7:0]        pr_depth;
    t_phase                   pr_phase;
    logic [KEY_LEN_BITS-1:0]  pr_name_idx;
    logic                     pr_name_bad;
    logic [OFFSET_BITS-1:0]   pr_span_start;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // scanner prediction
    // ------------------------------------------------------------------

    // space, tab, lf, vt, ff, cr
    function automatic logic is_space_byte(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic t_result make_report(input t_status st, input logic [15:0] first,
                                            input logic [16:0] past);
        t_result r;
        r.status      = st;
        r.value_begin = first;
        r.value_end   = past;
        return r;
    endfunction

    // everything but the key returns to its reset value between documents
    function automatic void restart_doc();
        pr_pos        = '0;
        pr_depth      = '0;
        pr_phase      = PH_OUTSIDE;
        pr_name_idx   = '0;
        pr_name_bad   = 1'b0;
        pr_span_start = '0;
    endfunction

    // compare one raw member-name byte against the key; the index saturates
    function automatic void match_name_byte(input logic [7:0] b);
        logic [2*KEY_WORD_BITS-1:0] key_all;
        key_all = {key_hi_copy, key_lo_copy};
        if (key_len_copy > KEY_LEN_MAX || pr_name_idx >= key_len_copy ||
            b != key_all[8*pr_name_idx[KEY_IDX_BITS-1:0] +: 8])
            pr_name_bad = 1'b1;
        if (pr_name_idx != NAME_IDX_SAT)
            pr_name_idx = pr_name_idx + 1'b1;
    endfunction

    // advance the mirrored scanner by one byte; returns 1 when a report is due
    function automatic logic scan_byte(input logic [7:0] b, input logic eod,
                                       output t_result rep);
        logic got;
        got = 1'b0;
        rep = '0;
        if (pr_phase != PH_DONE) begin
            if (pr_pos[OFFSET_BITS]) begin
                // offset no longer fits the span fields
                rep      = make_report(ST_TOO_LONG, '0, '0);
                pr_phase = PH_DONE;
                got      = 1'b1;
            end else begin
                case (pr_phase)
                    PH_OUTSIDE: begin
                        if (b == CH_QUOTE) begin
                            pr_phase    = PH_NAME;
                            pr_name_idx = '0;
                            pr_name_bad = (pr_depth != DEPTH_TOP);
                        end else if (b == CH_LBRACE || b == CH_LBRACK) begin
                            if (pr_depth < DEPTH_MAX) pr_depth = pr_depth + 8'sd1;
                        end else if (b == CH_RBRACE || b == CH_RBRACK) begin
                            if (pr_depth > DEPTH_MIN) pr_depth = pr_depth - 8'sd1;
                        end
                    end
                    PH_NAME: begin
                        if (b == CH_QUOTE) begin
                            if (!pr_name_bad && pr_name_idx == key_len_copy &&
                                key_len_copy <= KEY_LEN_MAX)
                                pr_phase = PH_SEEK_COLON;
                            else
                                pr_phase = PH_OUTSIDE;
                        end else begin
                            match_name_byte(b);
                            if (b == CH_BSLASH) pr_phase = PH_NAME_ESC;
                        end
                    end
                    PH_NAME_ESC: begin
                        match_name_byte(b);
                        pr_phase = PH_NAME;
                    end
                    PH_SEEK_COLON: begin
                        if (b == CH_COLON) pr_phase = PH_SKIP_WS;
                    end
                    PH_SKIP_WS: begin
                        if (!is_space_byte(b)) begin
                            pr_span_start = pr_pos[OFFSET_BITS-1:0];
                            if (b == CH_QUOTE) begin
                                pr_phase = PH_VAL_STR;
                            end else if (b == CH_COMMA || b == CH_RBRACE) begin
                                // empty bare value
                                rep      = make_report(ST_FOUND, pr_span_start, pr_pos);
                                pr_phase = PH_DONE;
                                got      = 1'b1;
                            end else begin
                                pr_phase = PH_VAL_BARE;
                            end
                        end
                    end
                    PH_VAL_BARE: begin
                        if (b == CH_COMMA || b == CH_RBRACE || is_space_byte(b)) begin
                            rep      = make_report(ST_FOUND, pr_span_start, pr_pos);
                            pr_phase = PH_DONE;
                            got      = 1'b1;
                        end
                    end
                    PH_VAL_STR: begin
                        if (b == CH_BSLASH) begin
                            pr_phase = PH_VAL_STR_ESC;
                        end else if (b == CH_QUOTE) begin
                            rep      = make_report(ST_FOUND, pr_span_start, pr_pos + 1'b1);
                            pr_phase = PH_DONE;
                            got      = 1'b1;
                        end
                    end
                    PH_VAL_STR_ESC: pr_phase = PH_VAL_STR;
                    default: ;
                endcase
            end
        end

        if (eod) begin
            if (!got && pr_phase != PH_DONE) begin
                if (pr_phase == PH_VAL_BARE)
                    rep = make_report(ST_FOUND, pr_span_start, pr_pos + 1'b1);
                else if (pr_phase == PH_OUTSIDE)
                    rep = make_report(ST_NOT_FOUND, '0, '0);
                else
                    rep = make_report(ST_MALFORMED, '0, '0);
                got = 1'b1;
            end
            restart_doc();
        end else if (pr_phase != PH_DONE && !pr_pos[OFFSET_BITS]) begin
            pr_pos = pr_pos + 1'b1;
        end
        return got;
    endfunction

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------

    // one byte transaction; valid stays high for a following byte
    task automatic send_byte(input logic [7:0] b, input logic eod);
        t_result rep;
        while ($urandom_range(99) < src_idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid           <= 1'b1;
        item_if.data_byte       <= b;
        item_if.end_of_document <= eod;
        do @(posedge clk); while (item_if.ready !== 1'b1);
        bytes_sent++;
        if (scan_byte(b, eod, rep))
            pending_reports.push_back(rep);
    endtask

    task automatic send_doc();
        foreach (doc_bytes[i])
            send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
        docs_sent++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            doc_bytes.push_back(s[i]);
    endtask

    task automatic run_doc(input string s);
        doc_bytes.delete();
        push_text(s);
        send_doc();
    endtask

    // no bytes in flight and every owed report delivered
    task automatic wait_idle();
        item_if.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write transaction; valid is lowered by the caller
    task automatic put_reg(input t_cfg_idx idx, input logic [KEY_WORD_BITS-1:0] data);
        cfg_if.valid      <= 1'b1;
        cfg_if.reg_index  <= idx;
        cfg_if.write_data <= data;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        reg_writes++;
        case (idx)
            CFG_KEY_LEN:  key_len_copy = data[KEY_LEN_BITS-1:0];
            CFG_KEY_LOW:  key_lo_copy  = data;
            CFG_KEY_HIGH: key_hi_copy  = data;
            default: ;
        endcase
    endtask

    task automatic write_key(input logic [63:0] len_word, input logic [63:0] lo,
                             input logic [63:0] hi);
        wait_idle();
        put_reg(CFG_KEY_LEN, len_word);
        put_reg(CFG_KEY_LOW, lo);
        put_reg(CFG_KEY_HIGH, hi);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [63:0] key_word(input string s, input int first);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < 8; i++)
            if (first + i < s.len()) w[8*i +: 8] = s[first + i];
        return w;
    endfunction

    task automatic load_key(input string s);
        write_key(64'(s.len()), key_word(s, 0), key_word(s, 8));
    endtask

    task automatic push_key_part(input int n);
        logic [2*KEY_WORD_BITS-1:0] key_all;
        key_all = {key_hi_copy, key_lo_copy};
        for (int i = 0; i < n; i++)
            doc_bytes.push_back(key_all[8*i +: 8]);
    endtask

    // none, or one or two whitespace bytes of any kind
    task automatic push_ws();
        if ($urandom_range(1)) begin
            repeat ($urandom_range(2, 1))
                doc_bytes.push_back(($urandom_range(5) == 5) ? CH_SPACE
                                                             : 8'(CH_TAB + $urandom_range(4)));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // key length is zero out of reset, so only the empty name matches
    task automatic test_empty_key_after_reset();
        run_doc("{\"\":5,\"x\":1}");
        run_doc("{\"a\":1}");
    endtask

    // every value shape, skip rules and each way a document can end
    task automatic test_value_forms();
        load_key("id");
        run_doc("{\"a\":\"x\",\"id\" : \"v\\\"w\" ,\"z\":0}");
        run_doc("{\"id\":\"\\\\\"}");
        run_doc("{\"id\":true ,\"q\":1}");
        run_doc("{\"id\":-12,\"q\":1}");
        run_doc("{\"id\":,\"q\":1}");
        run_doc("{\"id\":}");
        run_doc("{\"id\":\t\r\n 123");
        run_doc("{\"id\" x :7}");
        run_doc("{\"id\"");
        run_doc("{\"id\": ");
        run_doc("{\"id\":\"abc");
        run_doc("{\"ab");
        run_doc("{\"x\":1}");
        run_doc("{\"o\":{\"id\":1},\"id\":[2]}");
        run_doc("{\"i\\d\":1,\"idx\":2,\"i\":3}");
        run_doc("{\"id\":\"a\"} \"id\":9");
        run_doc("\"id\":1");
        run_doc("}{\"id\":1");
    endtask

    // full-width keys, register extremes, escapes inside the key, oversized lengths
    task automatic test_key_registers();
        load_key("abcdefghijklmnop");
        run_doc("{\"abcdefghijklmnop\":1}");
        run_doc("{\"abcdefghijklmno\":1}");
        run_doc("{\"abcdefghijklmnopq\":1}");

        load_key("a\\\"b");
        run_doc("{\"a\\\"b\":\"q\"}");

        // key of eight all-ones bytes then eight zero bytes
        write_key(64'(KEY_BYTES), '1, '0);
        doc_bytes.delete();
        push_text("{\"");
        push_key_part(KEY_BYTES);
        push_text("\":1}");
        send_doc();
        doc_bytes.delete();
        push_text("{\"");
        push_key_part(KEY_BYTES - 1);
        push_text("\":1}");
        send_doc();

        // all ones: length 31 can never match
        write_key('1, '1, '1);
        doc_bytes.delete();
        push_text("{\"");
        push_key_part(KEY_BYTES);
        push_text("\":1}");
        send_doc();

        load_key("abcdefghijklmnopq");
        run_doc("{\"abcdefghijklmnopq\":1}");
    endtask

    // depth must clamp at both ends instead of wrapping
    task automatic test_depth_saturation();
        load_key("k");
        doc_bytes.delete();
        repeat (128) doc_bytes.push_back(CH_LBRACK);
        repeat (126) doc_bytes.push_back(CH_RBRACK);
        push_text("\"k\":5}");
        send_doc();
        doc_bytes.delete();
        repeat (129) doc_bytes.push_back(CH_RBRACE);
        repeat (129) doc_bytes.push_back(CH_LBRACE);
        push_text("\"k\":6");
        send_doc();
    endtask

    task automatic load_random_key();
        int          r;
        logic [63:0] len_word;
        logic [63:0] lo;
        logic [63:0] hi;
        r        = $urandom_range(99);
        len_word = {$urandom, $urandom};
        if (r < 8)
            len_word[KEY_LEN_BITS-1:0] = '0;
        else if (r < 18)
            len_word[KEY_LEN_BITS-1:0] = KEY_LEN_MAX;
        else if (r < 24)
            len_word[KEY_LEN_BITS-1:0] = 5'($urandom_range(31, KEY_BYTES + 1));
        else
            len_word[KEY_LEN_BITS-1:0] = 5'($urandom_range(12, 1));
        for (int i = 0; i < 8; i++) begin
            lo[8*i +: 8] = ($urandom_range(6) == 0) ? 8'($urandom) : 8'("a" + $urandom_range(25));
            hi[8*i +: 8] = ($urandom_range(6) == 0) ? 8'($urandom) : 8'("a" + $urandom_range(25));
        end
        write_key(len_word, lo, hi);
    endtask

    // mostly objects with the key among other members, some truncated,
    // the rest structural noise or raw bytes
    task automatic build_random_doc();
        int    kind;
        int    kl;
        int    members;
        int    pick;
        int    cut;
        string noise;
        noise = "{}[]\":,\\ \ta1";
        kl    = (key_len_copy > KEY_LEN_MAX) ? KEY_BYTES : int'(key_len_copy);
        kind  = $urandom_range(99);
        doc_bytes.delete();
        if (kind < 78) begin
            if ($urandom_range(9) == 0) push_ws();
            doc_bytes.push_back(($urandom_range(9) == 0) ? CH_LBRACK : CH_LBRACE);
            members = $urandom_range(4);
            for (int m = 0; m < members; m++) begin
                if (m != 0) doc_bytes.push_back(CH_COMMA);
                push_ws();
                doc_bytes.push_back(CH_QUOTE);
                pick = $urandom_range(9);
                if (pick < 5) begin
                    push_key_part(kl);
                end else if (pick == 5) begin
                    push_key_part(kl);
                    push_text("z");
                end else if (pick == 6) begin
                    push_key_part((kl > 0) ? kl - 1 : 0);
                end else if (pick == 7) begin
                    doc_bytes.push_back(CH_BSLASH);
                    doc_bytes.push_back(8'($urandom));
                end else begin
                    repeat ($urandom_range(3)) doc_bytes.push_back(8'("a" + $urandom_range(25)));
                end
                doc_bytes.push_back(CH_QUOTE);
                push_ws();
                if ($urandom_range(14) == 0) push_text("x");
                doc_bytes.push_back(CH_COLON);
                push_ws();
                pick = $urandom_range(9);
                if (pick < 4) begin
                    doc_bytes.push_back(CH_QUOTE);
                    repeat ($urandom_range(5)) begin
                        if ($urandom_range(4) == 0) begin
                            doc_bytes.push_back(CH_BSLASH);
                            doc_bytes.push_back(8'($urandom));
                        end else begin
                            doc_bytes.push_back(8'("a" + $urandom_range(25)));
                        end
                    end
                    doc_bytes.push_back(CH_QUOTE);
                end else if (pick < 7) begin
                    repeat ($urandom_range(4, 1))
                        doc_bytes.push_back(8'("-" + $urandom_range(12)));
                end else if (pick == 8) begin
                    // key one level down must not match
                    doc_bytes.push_back(CH_LBRACE);
                    doc_bytes.push_back(CH_QUOTE);
                    push_key_part(kl);
                    doc_bytes.push_back(CH_QUOTE);
                    doc_bytes.push_back(CH_COLON);
                    push_text("1");
                    doc_bytes.push_back(CH_RBRACE);
                end else if (pick == 9) begin
                    doc_bytes.push_back(CH_LBRACK);
                    push_text("2");
                    doc_bytes.push_back(CH_RBRACK);
                end
            end
            doc_bytes.push_back(CH_RBRACE);
            if ($urandom_range(3) == 0) push_ws();
            if ($urandom_range(9) == 0) begin
                cut = $urandom_range(doc_bytes.size(), 1);
                while (doc_bytes.size() > cut) void'(doc_bytes.pop_back());
            end
        end else if (kind < 92) begin
            repeat ($urandom_range(24, 1)) begin
                if ($urandom_range(4) == 0)
                    push_key_part(($urandom_range(1) == 0) ? kl : 1);
                else
                    doc_bytes.push_back(noise[$urandom_range(noise.len() - 1)]);
            end
        end else begin
            repeat ($urandom_range(16, 1)) doc_bytes.push_back(8'($urandom));
        end
        if (doc_bytes.size() == 0) doc_bytes.push_back(CH_RBRACE);
    endtask

    // random documents under one idle mix, with a fresh key every few documents
    task automatic test_random_documents(input int src_pct, input int snk_pct,
                                         input int byte_goal);
        int start_bytes;
        int start_docs;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        start_bytes  = bytes_sent;
        start_docs   = docs_sent;
        while (bytes_sent - start_bytes < byte_goal) begin
            if ((docs_sent - start_docs) % 8 == 0) load_random_key();
            build_random_doc();
            send_doc();
        end
    endtask

    // ------------------------------------------------------------------
    // result receiver and checker
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        t_result want;
        res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (pending_reports.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTED)
                    $display("unexpected report: status %0d begin %0d end %0d",
                             res_if.status, res_if.value_begin, res_if.value_end);
            end else begin
                want = pending_reports.pop_front();
                results_checked++;
                if (res_if.status !== want.status || res_if.value_begin !== want.value_begin ||
                    res_if.value_end !== want.value_end) begin
                    err_count++;
                    if (err_count <= MAX_REPORTED)
                        $display("report %0d: expected status %0d begin %0d end %0d, got status %0d begin %0d end %0d",
                                 results_checked, want.status, want.value_begin,
                                 want.value_end, res_if.status, res_if.value_begin,
                                 res_if.value_end);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, pending_reports.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        rst_n                   = 1'b0;
        item_if.valid           = 1'b0;
        item_if.data_byte       = '0;
        item_if.end_of_document = 1'b0;
        cfg_if.valid            = 1'b0;
        cfg_if.reg_index        = '0;
        cfg_if.write_data       = '0;
        key_len_copy            = '0;
        key_lo_copy             = '0;
        key_hi_copy             = '0;
        restart_doc();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // sender idles lightly, receiver heavily
        src_idle_pct = 17;
        snk_idle_pct = 62;
        test_empty_key_after_reset();
        test_value_forms();
        test_key_registers();
        test_depth_saturation();
        test_random_documents(17, 62, 40);
        // roles swapped, then no idling at all
        test_random_documents(62, 17, 40);
        test_random_documents(0, 0, 40);

        // drain whatever is still owed, bounded
        item_if.valid <= 1'b0;
        for (int w = 0; w < 1000 && pending_reports.size() != 0; w++) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        err_count += pending_reports.size();

        $display("scanned %0d documents (%0d bytes) over %0d key register writes",
                 docs_sent, bytes_sent, reg_writes);
        $display("checked %0d reports incl. depth clamping, key extremes and idle mixes",
                 results_checked);
        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
